// ===== rtl/core/bpc_pkg.sv =====
package bpc_pkg;

    localparam int DIV_CELLS = 64;

    localparam logic [1:0] CFG_TEMP   = 2'd0;
    localparam logic [1:0] CFG_PRESSA = 2'd1;
    localparam logic [1:0] CFG_PRESSB = 2'd2;
    localparam logic [1:0] CFG_P9     = 2'd3;

    localparam logic signed [24:0] TFINE_OFFSET  = 25'sd128000;
    localparam logic [20:0]        PRESS_BASE    = 21'd1048576;
    localparam logic [63:0]        SCALE_DIV     = 64'd3125;
    localparam logic signed [63:0] BIAS_47       = 64'sh0000_8000_0000_0000;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_coeffs;

    // word moving down the divider chain
    typedef struct packed {
        logic [63:0] num;
        logic [30:0] rem;
        logic [30:0] ud;
        logic        qneg;
        logic        dz;
        logic [31:0] tfine;
    } t_div_word;

endpackage

// ===== rtl/core/barometric_pressure_compensation_core.sv =====
// Structure: an accepted word passes 10 front stages, 64 divider cells and 5 back
// stages to its result, one quotient bit resolved per cell.
// Throughput: one word per cycle unless stalled; stages move when the next is free.
// Reset: synchronous, active low; clears all stage valid bits and the
// coefficient registers to zero.
module barometric_pressure_compensation_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [19:0]        i_raw_pressure,
    input  logic [19:0]        i_raw_temperature,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [31:0]        o_pressure_q24_8,
    output logic signed [31:0] o_fine_temperature,
    output logic               o_divide_by_zero,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data
);

    logic [47:0] r_temp;
    logic [63:0] r_pa;
    logic [63:0] r_pb;
    logic [15:0] r_p9;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp <= '0;
            r_pa   <= '0;
            r_pb   <= '0;
            r_p9   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bpc_pkg::CFG_TEMP:   r_temp <= i_cfg_data[47:0];
                bpc_pkg::CFG_PRESSA: r_pa   <= i_cfg_data;
                bpc_pkg::CFG_PRESSB: r_pb   <= i_cfg_data;
                bpc_pkg::CFG_P9:     r_p9   <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    bpc_pkg::t_coeffs coef;
    always_comb begin
        coef.t1 = r_temp[15:0];
        coef.t2 = $signed(r_temp[31:16]);
        coef.t3 = $signed(r_temp[47:32]);
        coef.p1 = r_pa[15:0];
        coef.p2 = $signed(r_pa[31:16]);
        coef.p3 = $signed(r_pa[47:32]);
        coef.p4 = $signed(r_pa[63:48]);
        coef.p5 = $signed(r_pb[15:0]);
        coef.p6 = $signed(r_pb[31:16]);
        coef.p7 = $signed(r_pb[47:32]);
        coef.p8 = $signed(r_pb[63:48]);
        coef.p9 = $signed(r_p9);
    end

    logic                   front_ready;
    logic                   dv [0:bpc_pkg::DIV_CELLS];
    logic                   dr [0:bpc_pkg::DIV_CELLS];
    bpc_pkg::t_div_word     dw [0:bpc_pkg::DIV_CELLS];

    bpc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (front_ready),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .i_coef            (coef),
        .o_valid           (dv[0]),
        .o_word            (dw[0]),
        .i_ready           (dr[0])
    );

    for (genvar g = 0; g < bpc_pkg::DIV_CELLS; g++) begin : g_div
        bpc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv[g]),
            .o_ready (dr[g]),
            .i_word  (dw[g]),
            .o_valid (dv[g+1]),
            .o_word  (dw[g+1]),
            .i_ready (dr[g+1])
        );
    end

    bpc_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (dv[bpc_pkg::DIV_CELLS]),
        .o_ready            (dr[bpc_pkg::DIV_CELLS]),
        .i_word             (dw[bpc_pkg::DIV_CELLS]),
        .i_coef             (coef),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_pressure_q24_8   (o_pressure_q24_8),
        .o_fine_temperature (o_fine_temperature),
        .o_divide_by_zero   (o_divide_by_zero)
    );

    assign o_stall = !front_ready;

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_by_zero |-> o_pressure_q24_8 == 32'd0)
        else $error("divide by zero word carries nonzero pressure");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_free_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && !dv[bpc_pkg::DIV_CELLS] |-> dr[bpc_pkg::DIV_CELLS])
        else $error("back end refuses a word while empty at its ends");

endmodule

// ===== rtl/core/bpc_front.sv =====
module bpc_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [19:0]            i_raw_pressure,
    input  logic [19:0]            i_raw_temperature,
    input  bpc_pkg::t_coeffs       i_coef,
    output logic                   o_valid,
    output bpc_pkg::t_div_word     o_word,
    input  logic                   i_ready
);

    logic [9:0] r_v;
    logic [9:0] rdy;

    always_comb begin
        rdy[9] = !r_v[9] || i_ready;
        for (int k = 8; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < 10; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 0: temperature differences
    logic signed [18:0] r_d1;
    logic signed [17:0] r_d2;
    logic [20:0]        r_pb0;
    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_d1  <= $signed({2'b00, i_raw_temperature[19:3]}) - $signed({2'b00, i_coef.t1, 1'b0});
            r_d2  <= $signed({2'b00, i_raw_temperature[19:4]}) - $signed({2'b00, i_coef.t1});
            r_pb0 <= bpc_pkg::PRESS_BASE - {1'b0, i_raw_pressure};
        end
    end

    // stage 1
    logic signed [34:0] r_taprod;
    logic signed [35:0] r_d2sq;
    logic [20:0]        r_pb1;
    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_taprod <= 35'(r_d1) * 35'(i_coef.t2);
            r_d2sq   <= 36'(r_d2) * 36'(r_d2);
            r_pb1    <= r_pb0;
        end
    end

    // stage 2
    logic signed [23:0] sq12;
    logic signed [23:0] r_ta;
    logic signed [39:0] r_tbprod;
    logic [20:0]        r_pb2;
    assign sq12 = 24'(r_d2sq >>> 12);
    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_ta     <= 24'(r_taprod >>> 11);
            r_tbprod <= 40'(sq12) * 40'(i_coef.t3);
            r_pb2    <= r_pb1;
        end
    end

    // stage 3: fine temperature
    logic signed [31:0] tfine;
    logic signed [31:0] r_tfine3;
    logic signed [24:0] r_v1;
    logic [20:0]        r_pb3;
    assign tfine = 32'(r_ta) + 32'(r_tbprod >>> 14);
    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_tfine3 <= tfine;
            r_v1     <= 25'(tfine) - bpc_pkg::TFINE_OFFSET;
            r_pb3    <= r_pb2;
        end
    end

    // stage 4
    logic signed [47:0] r_vsq;
    logic signed [40:0] r_v1p5;
    logic signed [40:0] r_v1p2;
    logic signed [31:0] r_tfine4;
    logic [20:0]        r_pb4;
    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r_vsq    <= 48'(r_v1) * 48'(r_v1);
            r_v1p5   <= 41'(r_v1) * 41'(i_coef.p5);
            r_v1p2   <= 41'(r_v1) * 41'(i_coef.p2);
            r_tfine4 <= r_tfine3;
            r_pb4    <= r_pb3;
        end
    end

    // stage 5
    logic signed [63:0] r_a6;
    logic signed [63:0] r_b3;
    logic signed [40:0] r_v1p5b;
    logic signed [40:0] r_v1p2b;
    logic signed [31:0] r_tfine5;
    logic [20:0]        r_pb5;
    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r_a6     <= 64'(r_vsq) * 64'(i_coef.p6);
            r_b3     <= 64'(r_vsq) * 64'(i_coef.p3);
            r_v1p5b  <= r_v1p5;
            r_v1p2b  <= r_v1p2;
            r_tfine5 <= r_tfine4;
            r_pb5    <= r_pb4;
        end
    end

    // stage 6
    logic signed [63:0] v2;
    logic signed [63:0] v1b;
    logic signed [63:0] r_v2;
    logic signed [63:0] r_s;
    logic signed [31:0] r_tfine6;
    logic [20:0]        r_pb6;
    assign v2  = r_a6 + (64'(r_v1p5b) <<< 17) + (64'(i_coef.p4) <<< 35);
    assign v1b = (r_b3 >>> 8) + (64'(r_v1p2b) <<< 12);
    always_ff @(posedge i_clk) begin
        if (rdy[6]) begin
            r_v2     <= v2;
            r_s      <= bpc_pkg::BIAS_47 + v1b;
            r_tfine6 <= r_tfine5;
            r_pb6    <= r_pb5;
        end
    end

    // stage 7
    logic [63:0]        r_m;
    logic [63:0]        r_npre;
    logic signed [31:0] r_tfine7;
    always_ff @(posedge i_clk) begin
        if (rdy[7]) begin
            r_m      <= r_s * {48'b0, i_coef.p1};
            r_npre   <= ({43'b0, r_pb6} << 31) - r_v2;
            r_tfine7 <= r_tfine6;
        end
    end

    // stage 8: divisor and numerator
    logic [30:0]        r_dvs;
    logic [63:0]        r_num;
    logic signed [31:0] r_tfine8;
    always_ff @(posedge i_clk) begin
        if (rdy[8]) begin
            r_dvs    <= r_m[63:33];
            r_num    <= r_npre * bpc_pkg::SCALE_DIV;
            r_tfine8 <= r_tfine7;
        end
    end

    // stage 9: magnitudes
    bpc_pkg::t_div_word r_w;
    always_ff @(posedge i_clk) begin
        if (rdy[9]) begin
            r_w.num   <= r_num[63] ? (64'd0 - r_num) : r_num;
            r_w.ud    <= r_dvs[30] ? (31'd0 - r_dvs) : r_dvs;
            r_w.rem   <= '0;
            r_w.qneg  <= r_num[63] ^ r_dvs[30];
            r_w.dz    <= (r_dvs == 31'd0);
            r_w.tfine <= r_tfine8;
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[9];
    assign o_word  = r_w;

endmodule

// ===== rtl/core/bpc_div_cell.sv =====
module bpc_div_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  bpc_pkg::t_div_word     i_word,
    output logic                   o_valid,
    output bpc_pkg::t_div_word     o_word,
    input  logic                   i_ready
);

    logic               r_valid;
    bpc_pkg::t_div_word r_word;
    bpc_pkg::t_div_word n_word;
    logic [31:0]        trial;
    logic               qbit;

    always_comb begin
        n_word = i_word;
        trial  = {i_word.rem, i_word.num[63]};
        qbit   = (trial >= {1'b0, i_word.ud});
        if (qbit) begin
            n_word.rem = 31'(trial - {1'b0, i_word.ud});
        end else begin
            n_word.rem = trial[30:0];
        end
        n_word.num = {i_word.num[62:0], qbit};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== rtl/core/bpc_back.sv =====
module bpc_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  bpc_pkg::t_div_word     i_word,
    input  bpc_pkg::t_coeffs       i_coef,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [31:0]            o_pressure_q24_8,
    output logic signed [31:0]     o_fine_temperature,
    output logic                   o_divide_by_zero
);

    logic [4:0] r_v;
    logic [4:0] rdy;

    always_comb begin
        rdy[4] = !r_v[4] || !i_stall;
        for (int k = 3; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < 5; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 0: quotient sign
    logic signed [63:0] r_p0;
    logic               r_dz0;
    logic [31:0]        r_tf0;
    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_p0  <= i_word.qneg ? $signed(64'd0 - i_word.num) : $signed(i_word.num);
            r_dz0 <= i_word.dz;
            r_tf0 <= i_word.tfine;
        end
    end

    // stage 1
    logic signed [50:0] ps;
    logic signed [50:0] r_ps1;
    logic signed [63:0] r_pp9;
    logic signed [63:0] r_e2p;
    logic signed [63:0] r_p1;
    logic               r_dz1;
    logic [31:0]        r_tf1;
    assign ps = r_p0[63:13];
    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_ps1 <= ps;
            r_pp9 <= 64'(ps) * 64'(i_coef.p9);
            r_e2p <= r_p0 * 64'(i_coef.p8);
            r_p1  <= r_p0;
            r_dz1 <= r_dz0;
            r_tf1 <= r_tf0;
        end
    end

    // stage 2: partial products of the square term, low 64 bits
    logic [63:0]        psx;
    logic [63:0]        r_lo;
    logic [31:0]        r_c1;
    logic [31:0]        r_c2;
    logic signed [63:0] r_e2p2;
    logic signed [63:0] r_p2;
    logic               r_dz2;
    logic [31:0]        r_tf2;
    logic [63:0]        pp9u;
    logic [63:0]        c1w;
    logic [63:0]        c2w;
    assign psx  = 64'(r_ps1);
    assign pp9u = r_pp9;
    assign c1w  = pp9u[31:0] * psx[63:32];
    assign c2w  = pp9u[63:32] * psx[31:0];
    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_lo   <= pp9u[31:0] * psx[31:0];
            r_c1   <= c1w[31:0];
            r_c2   <= c2w[31:0];
            r_e2p2 <= r_e2p;
            r_p2   <= r_p1;
            r_dz2  <= r_dz1;
            r_tf2  <= r_tf1;
        end
    end

    // stage 3
    logic signed [63:0] sqp;
    logic signed [63:0] r_sum;
    logic               r_dz3;
    logic [31:0]        r_tf3;
    assign sqp = $signed(r_lo + {r_c1 + r_c2, 32'b0});
    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_sum <= r_p2 + (sqp >>> 25) + (r_e2p2 >>> 19);
            r_dz3 <= r_dz2;
            r_tf3 <= r_tf2;
        end
    end

    // stage 4: output word
    logic signed [63:0] pf;
    logic [31:0]        clamp;
    logic [31:0]        r_press;
    logic               r_dz4;
    logic [31:0]        r_tf4;
    assign pf = (r_sum >>> 8) + (64'(i_coef.p7) <<< 4);
    always_comb begin
        if (r_dz3 || pf[63]) begin
            clamp = '0;
        end else if (pf[62:32] != '0) begin
            clamp = '1;
        end else begin
            clamp = pf[31:0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r_press <= clamp;
            r_dz4   <= r_dz3;
            r_tf4   <= r_tf3;
        end
    end

    assign o_ready            = rdy[0];
    assign o_valid            = r_v[4];
    assign o_pressure_q24_8   = r_press;
    assign o_fine_temperature = $signed(r_tf4);
    assign o_divide_by_zero   = r_dz4;

endmodule

// ===== tb/bpc_checker.sv =====
module bpc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall_in,
    input  logic [19:0]        i_raw_pressure,
    input  logic [19:0]        i_raw_temperature,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [31:0]        i_pressure_q24_8,
    input  logic [31:0]        i_fine_temperature,
    input  logic               i_divide_by_zero,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] press;
        logic [31:0] tfine;
        logic        dz;
    } t_reading;

    logic [47:0] temp_c;
    logic [63:0] pa_c, pb_c;
    logic [15:0] p9_c;
    t_reading    expected_q[$];

    function automatic logic signed [63:0] sf(logic [63:0] w, int pos);
        return 64'(signed'(w[pos +: 16]));
    endfunction

    function automatic t_reading compensate(logic [19:0] adc_p, logic [19:0] adc_t);
        t_reading r;
        logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] d1, d2, ta, tb, tf, v1, v2, p, ps, e1, e2, num;
        logic [63:0] un, ud, q;
        t1 = {48'd0, temp_c[15:0]};
        t2 = sf(temp_c, 16);
        t3 = sf(temp_c, 32);
        p1 = {48'd0, pa_c[15:0]};
        p2 = sf(pa_c, 16);
        p3 = sf(pa_c, 32);
        p4 = sf(pa_c, 48);
        p5 = sf(pb_c, 0);
        p6 = sf(pb_c, 16);
        p7 = sf(pb_c, 32);
        p8 = sf(pb_c, 48);
        p9 = sf({48'd0, p9_c}, 0);
        d1 = (64'(adc_t) >> 3) - (t1 <<< 1);
        ta = (d1 * t2) >>> 11;
        d2 = (64'(adc_t) >> 4) - t1;
        tb = (((d2 * d2) >>> 12) * t3) >>> 14;
        tf = ta + tb;
        v1 = tf - 64'sd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) <<< 17);
        v2 = v2 + (p4 <<< 35);
        v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
        v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
        r.tfine = tf[31:0];
        r.press = '0;
        r.dz = 1'b0;
        if (v1 == 0) begin
            r.dz = 1'b1;
        end else begin
            p = 64'sd1048576 - 64'(adc_p);
            num = ((p <<< 31) - v2) * 64'sd3125;
            un = num[63] ? -num : num;
            ud = v1[63] ? -v1 : v1;
            q = un / ud;
            p = (num[63] != v1[63]) ? -q : q;
            ps = p >>> 13;
            e1 = (p9 * ps * ps) >>> 25;
            e2 = (p8 * p) >>> 19;
            p = ((p + e1 + e2) >>> 8) + (p7 <<< 4);
            if (p < 0) r.press = '0;
            else if (p > 64'sh0000_0000_FFFF_FFFF) r.press = '1;
            else r.press = p[31:0];
        end
        return r;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_reading e;
        int       n;
        n = 0;
        if (!i_rst_n) begin
            temp_c <= '0;
            pa_c <= '0;
            pb_c <= '0;
            p9_c <= '0;
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bpc_pkg::CFG_TEMP:   temp_c <= i_cfg_data[47:0];
                    bpc_pkg::CFG_PRESSA: pa_c <= i_cfg_data;
                    bpc_pkg::CFG_PRESSB: pb_c <= i_cfg_data;
                    bpc_pkg::CFG_P9:     p9_c <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in)
                expected_q.push_back(compensate(i_raw_pressure, i_raw_temperature));
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected word");
                    n++;
                end else begin
                    e = expected_q.pop_front();
                    if (e.press !== i_pressure_q24_8) begin
                        $error("pressure_q24_8 exp %h got %h", e.press, i_pressure_q24_8);
                        n++;
                    end
                    if (e.tfine !== i_fine_temperature) begin
                        $error("fine_temperature exp %h got %h", e.tfine,
                               i_fine_temperature);
                        n++;
                    end
                    if (e.dz !== i_divide_by_zero) begin
                        $error("divide_by_zero exp %b got %b", e.dz, i_divide_by_zero);
                        n++;
                    end
                end
            end
            o_errors <= o_errors + n;
        end
    end
endmodule

// ===== tb/tb_barometric_pressure_compensation_core.sv =====
module tb_barometric_pressure_compensation_core;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0, i_rst_n = 0;
    logic        i_valid = 0, i_stall = 0;
    logic [19:0] i_raw_pressure = '0, i_raw_temperature = '0;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_idx = bpc_pkg::CFG_TEMP;
    logic [63:0] i_cfg_data = '0;
    logic        o_stall, o_valid, o_divide_by_zero;
    logic [31:0] o_pressure_q24_8;
    logic signed [31:0] o_fine_temperature;
    int          errors, pending;
    bit          hold_sink = 0;

    always #5 i_clk = ~i_clk;

    barometric_pressure_compensation_core dut (.*);

    bpc_checker chk (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall),
        .i_raw_pressure, .i_raw_temperature,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_pressure_q24_8(o_pressure_q24_8),
        .i_fine_temperature(o_fine_temperature),
        .i_divide_by_zero(o_divide_by_zero),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    task automatic send_word(logic [19:0] rp, logic [19:0] rt);
        i_valid <= 1'b1;
        i_raw_pressure <= rp;
        i_raw_temperature <= rt;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic idle_valid(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain;
        idle_valid(1);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // typical sensor trim values
    task automatic write_typical;
        write_reg(bpc_pkg::CFG_TEMP, {16'hFC18, 16'h6A12, 16'h6E5E});
        write_reg(bpc_pkg::CFG_PRESSA, {16'h0AE2, 16'hFFFD, 16'hD5D0, 16'h9277});
        write_reg(bpc_pkg::CFG_PRESSB, {16'h0A40, 16'hFFC2, 16'hFFF9, 16'h008C});
        write_reg(bpc_pkg::CFG_P9, 64'h1770);
    endtask

    task automatic write_random;
        write_reg(bpc_pkg::CFG_TEMP, {$urandom, $urandom});
        write_reg(bpc_pkg::CFG_PRESSA, {$urandom, $urandom});
        write_reg(bpc_pkg::CFG_PRESSB, {$urandom, $urandom});
        write_reg(bpc_pkg::CFG_P9, {$urandom, $urandom});
    endtask

    task automatic random_phase(int n);
        int left;
        left = n;
        while (left > 0) begin
            for (int b = $urandom_range(1, 40); b > 0 && left > 0; b--, left--)
                send_word($urandom, $urandom);
            if ($urandom_range(0, 2) != 0) idle_valid($urandom_range(1, 8));
        end
        drain();
    endtask

    always @(posedge i_clk) begin
        if (hold_sink) i_stall <= 1'b1;
        else if ($urandom_range(0, 99) < 40 && ($urandom & 1)) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(0, 3) == 0);
    end

    initial begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // all coefficients zero: divisor zero
        send_word('0, '0);
        send_word('1, '1);
        drain();
        write_typical();
        send_word(20'h65A00, 20'h7E100);
        send_word('0, '0);
        send_word('1, '1);
        send_word('0, '1);
        send_word('1, '0);
        send_word(20'hAAAAA, 20'h55555);
        send_word(20'h55555, 20'hAAAAA);
        drain();
        // extreme coefficients: overflow, clamps, division edge
        write_reg(bpc_pkg::CFG_TEMP, {16'h8000, 16'h8000, 16'hFFFF});
        write_reg(bpc_pkg::CFG_PRESSA, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF});
        write_reg(bpc_pkg::CFG_PRESSB, {16'h8000, 16'h8000, 16'h8000, 16'h8000});
        write_reg(bpc_pkg::CFG_P9, 64'h8000);
        send_word('0, '0);
        send_word('1, '1);
        send_word('0, '1);
        drain();
        write_reg(bpc_pkg::CFG_TEMP, {16'h7FFF, 16'h7FFF, 16'h0000});
        write_reg(bpc_pkg::CFG_PRESSA, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001});
        write_reg(bpc_pkg::CFG_PRESSB, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
        write_reg(bpc_pkg::CFG_P9, 64'hFFFF_FFFF_FFFF_7FFF);
        send_word('0, '0);
        send_word('1, '1);
        send_word('1, '0);
        drain();
        // long sink hold: fill the pipe
        write_typical();
        hold_sink = 1;
        fork
            repeat (300) @(posedge i_clk);
            for (int k = 0; k < 150; k++) send_word($urandom, $urandom);
        join_any
        hold_sink = 0;
        wait fork;
        drain();
        random_phase(500);
        write_random();
        random_phase(400);
        write_random();
        random_phase(400);
        write_reg(bpc_pkg::CFG_P9, '0);
        random_phase(200);
        write_typical();
        random_phase(200);
        repeat (100) @(posedge i_clk);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/bpc_pkg.sv
rtl/core/bpc_front.sv
rtl/core/bpc_div_cell.sv
rtl/core/bpc_back.sv
rtl/core/barometric_pressure_compensation_core.sv
tb/bpc_checker.sv
tb/tb_barometric_pressure_compensation_core.sv
